FILE: hw/rtl/skrt_pkg.sv
// ----------------------------------------------------------------------------
// skrt_pkg: shared definitions of the sorted key/record table
// Widths, default sizes, sequencer states and the result word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package skrt_pkg;

    localparam int DEF_CAPACITY     = 256;
    localparam int DEF_RECORD_BYTES = 4;

    localparam int KEY_W      = 32;
    localparam int REC_MAX_W  = 32;
    localparam int POS_OUT_W  = 9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAST,
        ST_SEARCH,
        ST_PROBE,
        ST_DECIDE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_RESULT
    } skrt_state_t;

    typedef struct packed {
        logic                 found;
        logic [POS_OUT_W-1:0] position;
        logic [REC_MAX_W-1:0] prev_record;
        logic                 rejected;
    } skrt_result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/skrt_store.sv
// ----------------------------------------------------------------------------
// skrt_store: entry memory of the sorted key/record table
// One write port and one read port with registered read data. Each entry
// holds a key in the low bits and its record above it.
// ----------------------------------------------------------------------------
`default_nettype none

module skrt_store
    import skrt_pkg::*;
#(
    parameter int DEPTH = DEF_CAPACITY,
    parameter int DW    = KEY_W + REC_MAX_W,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/skrt_ctrl.sv
// ----------------------------------------------------------------------------
// skrt_ctrl: search and insert sequencer
// Runs the append check, the binary search and the shift-up of entries on
// an insert, all through one memory port pair and one shared pair of key compares.
// ----------------------------------------------------------------------------
`default_nettype none

module skrt_ctrl
    import skrt_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int REC_W    = REC_MAX_W,
    localparam int AW      = $clog2(CAPACITY),
    localparam int CW      = $clog2(CAPACITY + 1),
    localparam int DW      = KEY_W + REC_W
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             in_action,
    input  wire logic [KEY_W-1:0] in_key,
    input  wire logic [REC_W-1:0] in_rec,
    output logic                  mem_wr_en,
    output logic      [AW-1:0]    mem_wr_addr,
    output logic      [DW-1:0]    mem_wr_data,
    output logic                  mem_rd_en,
    output logic      [AW-1:0]    mem_rd_addr,
    input  wire logic [DW-1:0]    mem_rd_data,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output skrt_result_t          res
);

    skrt_state_t      state_reg, state_next;
    logic             action_reg, action_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [REC_W-1:0] rec_reg, rec_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    lo_reg, lo_next;
    logic [CW-1:0]    hi_reg, hi_next;
    logic [CW-1:0]    mid_reg, mid_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    pos_reg, pos_next;
    logic             hit_reg, hit_next;
    logic [REC_W-1:0] old_reg, old_next;
    logic             rej_reg, rej_next;

    logic             accept;
    logic [KEY_W-1:0] rd_key;
    logic [REC_W-1:0] rd_rec;
    logic             key_eq;
    logic             key_gt;
    logic [CW:0]      mid_sum;
    logic [CW-1:0]    mid_calc;

    assign accept = in_valid && in_ready;
    assign rd_key = mem_rd_data[KEY_W-1:0];
    assign rd_rec = mem_rd_data[DW-1:KEY_W];

    // The same equal and greater-than compares serve both the append check and every probe.
    assign key_eq = (rd_key == key_reg);
    assign key_gt = (key_reg > rd_key);

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc = mid_sum[CW:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        key_reg    <= key_next;
        rec_reg    <= rec_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        hit_reg    <= hit_next;
        old_reg    <= old_next;
        rej_reg    <= rej_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (count_reg == '0) ? ST_DECIDE : ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = key_gt ? ST_DECIDE : ST_SEARCH;
            end
            ST_SEARCH:
            begin
                state_next = (lo_reg < hi_reg) ? ST_PROBE : ST_DECIDE;
            end
            ST_PROBE:
            begin
                state_next = key_eq ? ST_DECIDE : ST_SEARCH;
            end
            ST_DECIDE:
            begin
                if (action_reg && !hit_reg && (count_reg != CW'(CAPACITY)))
                begin
                    state_next = ST_SHIFT_RD;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_SHIFT_RD:
            begin
                state_next = (idx_reg > pos_reg) ? ST_SHIFT_WR : ST_RESULT;
            end
            ST_SHIFT_WR:
            begin
                state_next = ST_SHIFT_RD;
            end
            ST_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        action_next = action_reg;
        key_next    = key_reg;
        rec_next    = rec_reg;
        count_next  = count_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        hit_next    = hit_reg;
        old_next    = old_reg;
        rej_next    = rej_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = pos_reg[AW-1:0];
        mem_wr_data = {rec_reg, key_reg};
        mem_rd_en   = 1'b0;
        mem_rd_addr = mid_calc[AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    action_next = in_action;
                    key_next    = in_key;
                    rec_next    = in_rec;
                    hit_next    = 1'b0;
                    old_next    = '0;
                    rej_next    = 1'b0;
                    pos_next    = '0;
                    // Fetch the last entry for the append check.
                    mem_rd_en   = (count_reg != '0);
                    mem_rd_addr = AW'(count_reg - CW'(1));
                end
            end
            ST_LAST:
            begin
                if (key_gt)
                begin
                    pos_next = count_reg;
                end
                else
                begin
                    lo_next = '0;
                    hi_next = count_reg;
                end
            end
            ST_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mem_rd_en = 1'b1;
                    mid_next  = mid_calc;
                end
                else
                begin
                    pos_next = lo_reg;
                end
            end
            ST_PROBE:
            begin
                if (key_eq)
                begin
                    hit_next = 1'b1;
                    pos_next = mid_reg;
                    old_next = action_reg ? rd_rec : '0;
                end
                else if (key_gt)
                begin
                    lo_next = mid_reg + CW'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
            end
            ST_DECIDE:
            begin
                if (action_reg)
                begin
                    if (hit_reg)
                    begin
                        mem_wr_en = 1'b1;
                    end
                    else if (count_reg == CW'(CAPACITY))
                    begin
                        rej_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = count_reg;
                    end
                end
            end
            ST_SHIFT_RD:
            begin
                if (idx_reg > pos_reg)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = AW'(idx_reg - CW'(1));
                end
                else
                begin
                    // Every later entry has moved up; drop the new one in.
                    mem_wr_en  = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            ST_SHIFT_WR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = idx_reg[AW-1:0];
                mem_wr_data = mem_rd_data;
                idx_next    = idx_reg - CW'(1);
            end
            ST_RESULT:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    assign res.found       = hit_reg;
    assign res.position    = POS_OUT_W'(pos_reg);
    assign res.prev_record = REC_MAX_W'(old_reg);
    assign res.rejected    = rej_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/sorted_key_record_table_unit.sv
// ----------------------------------------------------------------------------
// sorted_key_record_table_unit: sorted key/record table with lookup and add
// Top level: stream ports, entry memory, sequencer and the output register.
// ----------------------------------------------------------------------------
// Each input word is a lookup (tuser 0) or an add (tuser 1) of a 32-bit key
// and its record; the block keeps up to CAPACITY records sorted by unsigned
// key and returns one result word per input word. Items are handled one at
// a time. A key above the last entry is settled by the append check alone;
// otherwise a binary search probes the table. An insert then moves every
// later entry up by one, each with a read and then a write through the
// single memory port pair, so the slowest insert is one at the front of a
// nearly full table. The next word is taken as soon as the result sits in
// the output register. An add of a new key to a full table leaves it
// unchanged and sets rejected.
`default_nettype none

module sorted_key_record_table_unit
    import skrt_pkg::*;
#(
    parameter int CAPACITY     = DEF_CAPACITY,
    parameter int RECORD_BYTES = DEF_RECORD_BYTES
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // seq_key[31:0], record_data[63:32]
    input  wire logic        s_axis_tuser,  // action
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [47:0] m_axis_tdata   // found[0], position[9:1],
                                            // prev_record[41:10], rejected[42]
);

    localparam int REC_W = (RECORD_BYTES >= 4) ? REC_MAX_W : 8 * RECORD_BYTES;
    localparam int AW    = $clog2(CAPACITY);
    localparam int DW    = KEY_W + REC_W;

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [DW-1:0] mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic [DW-1:0] mem_rd_data;

    logic          res_valid;
    logic          res_ready;
    skrt_result_t  res;

    logic          out_valid_reg, out_valid_next;
    skrt_result_t  out_res_reg, out_res_next;

    skrt_store #(
        .DEPTH (CAPACITY),
        .DW    (DW)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    skrt_ctrl #(
        .CAPACITY (CAPACITY),
        .REC_W    (REC_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_action   (s_axis_tuser),
        .in_key      (s_axis_tdata[KEY_W-1:0]),
        .in_rec      (s_axis_tdata[KEY_W +: REC_W]),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // The output register frees the sequencer as soon as a result is parked.
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_res_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_res_reg.rejected, out_res_reg.prev_record,
                            out_res_reg.position, out_res_reg.found};

endmodule

`default_nettype wire
